[sv/cfb_pkg.sv]
// Shared types, constants and the CRC-8 step function of the CRSF frame builder.
package cfb_pkg;

	localparam logic [5:0] MAX_PAYLOAD  = 6'd60;
	localparam logic [7:0] LEN_OVERHEAD = 8'd2;
	localparam logic [7:0] CRC_RESET_POLY = 8'hD5;
	localparam logic [7:0] CRC_TOP_BIT  = 8'h80;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified input item, as handed from front to back.
	typedef struct packed {
		logic [7:0] dest;
		logic [7:0] ftype;
		logic [7:0] len_byte;
		logic [7:0] data;
		logic       first;     // header bytes go out ahead of the payload byte
		logic       has_data;  // payload byte goes out
		logic       last;      // CRC byte closes the frame after this item
	} cmd_t;

	// MSB-first CRC-8 over one byte.
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			v = ((v & CRC_TOP_BIT) != 8'd0) ? ((v << 1) ^ poly) : (v << 1);
		end
		return v;
	endfunction

endpackage

[sv/cfb_ifs.sv]
// Channel interfaces: input items, output bytes and the configuration write channel.
interface cfb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] dest_address;
	logic [7:0] frame_type;
	logic [5:0] pay_len;
	logic [7:0] data_byte;
	modport source (output valid, dest_address, frame_type, pay_len, data_byte,
		input ready);
	modport sink (input valid, dest_address, frame_type, pay_len, data_byte,
		output ready);
endinterface

interface cfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       frame_end;
	modport source (output valid, out_byte, last_of_run, frame_end, input ready);
	modport sink (input valid, out_byte, last_of_run, frame_end, output ready);
endinterface

interface cfb_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] wdata;
	modport source (output valid, wdata, input ready);
	modport sink (input valid, wdata, output ready);
endinterface

[sv/crsf_frame_builder_crc8.sv]
// Top level of the CRSF frame builder with CRC-8.
//
// Usage:
//   item  : input channel, one payload byte per transaction. On the first
//           transaction of a frame dest_address, frame_type and
//           pay_len are also taken (length saturates at 60).
//   frame : output channel, one frame byte per transaction. last_of_run
//           marks the final byte caused by an input transaction, frame_end
//           marks the closing CRC byte.
//   cfg   : write channel for the CRC-8 polynomial; always ready.
// Path: an item is first written into the two-entry queue; its bytes are
//   then registered in the back end's output register before being offered.
// Throughput: one output byte per cycle from the back end unless stalled,
//   so a payload item gives one byte (two if it closes the frame), a frame's
//   first item four or five (header bytes, payload byte or CRC). The byte
//   serializer sets the rate; the two-entry queue lets the front keep going.
// Reset: idle between frames, CRC cleared, polynomial 0xD5, queue empty.
// Stall: when frame.ready is low the output byte holds; the queue fills
//   and item.ready drops once two commands are waiting.
module crsf_frame_builder_crc8 (
	input  logic       clk,
	input  logic       arst_n,
	cfb_in_if.sink     item,
	cfb_out_if.source  frame,
	cfb_cfg_if.sink    cfg
);

	logic [7:0]    poly_q;
	cfb_pkg::cmd_t front_cmd;
	cfb_pkg::cmd_t head_cmd;
	logic          push;
	logic          full;
	logic          head_valid;
	logic          pop;

	// Polynomial register; the user must write it only while the block is idle, the block does not enforce this.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= cfb_pkg::CRC_RESET_POLY;
		end else if (cfg.valid && cfg.ready) begin
			poly_q <= cfg.wdata;
		end
	end

	// Front: classify items against frame position.
	cfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cmd      (front_cmd),
		.cmd_push (push),
		.cmd_full (full)
	);

	// Decoupling queue.
	cfb_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_cmd    (front_cmd),
		.push      (push),
		.full      (full),
		.rd_cmd    (head_cmd),
		.not_empty (head_valid),
		.pop       (pop)
	);

	// Back: byte serializer and CRC.
	cfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.poly       (poly_q),
		.head       (head_cmd),
		.head_valid (head_valid),
		.pop        (pop),
		.frame      (frame)
	);

endmodule

[sv/cfb_front.sv]
// Front end: accepts input items, tracks frame position and classifies each item.
module cfb_front (
	input  logic          clk,
	input  logic          arst_n,
	cfb_in_if.sink        item,
	output cfb_pkg::cmd_t cmd,
	output logic          cmd_push,
	input  logic          cmd_full
);

	logic       in_frame_q;
	logic [5:0] bytes_left_q;
	logic [5:0] len_sat;
	logic [5:0] remaining;
	logic       accept;

	assign item.ready = !cmd_full;
	assign accept     = item.valid && item.ready;
	assign cmd_push   = accept;

	assign len_sat = (item.pay_len > cfb_pkg::MAX_PAYLOAD) ?
		cfb_pkg::MAX_PAYLOAD : item.pay_len;

	always_comb begin
		cmd.dest     = item.dest_address;
		cmd.ftype    = item.frame_type;
		cmd.len_byte = {2'b00, len_sat} + cfb_pkg::LEN_OVERHEAD;
		cmd.data     = item.data_byte;
		if (!in_frame_q) begin
			cmd.first    = 1'b1;
			cmd.has_data = (len_sat != 6'd0);
			remaining    = (len_sat != 6'd0) ? (len_sat - 6'd1) : 6'd0;
		end else begin
			cmd.first    = 1'b0;
			cmd.has_data = 1'b1;
			remaining    = bytes_left_q - 6'd1;
		end
		cmd.last = (remaining == 6'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			bytes_left_q <= 6'd0;
		end else if (accept) begin
			in_frame_q   <= !cmd.last;
			bytes_left_q <= remaining;
		end
	end

endmodule

[sv/cfb_cmd_queue.sv]
// Two-entry command queue between front and back.
module cfb_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  cfb_pkg::cmd_t wr_cmd,
	input  logic          push,
	output logic          full,
	output cfb_pkg::cmd_t rd_cmd,
	output logic          not_empty,
	input  logic          pop
);

	cfb_pkg::cmd_t                     mem_q [cfb_pkg::QUEUE_DEPTH];
	logic [cfb_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [cfb_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [cfb_pkg::QCNT_W-1:0]        count_q;

	assign full      = (count_q == cfb_pkg::QCNT_W'(cfb_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == cfb_pkg::QPTR_W'(cfb_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == cfb_pkg::QPTR_W'(cfb_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/cfb_back.sv]
// Back end: serializes each command into frame bytes and runs the CRC.
module cfb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    poly,
	input  cfb_pkg::cmd_t head,
	input  logic          head_valid,
	output logic          pop,
	cfb_out_if.source     frame
);

	typedef enum logic [2:0] {ST_DEST, ST_LEN, ST_TYPE, ST_DATA, ST_CRC} step_t;

	step_t      step_q;
	step_t      cur;
	step_t      nxt;
	logic       started_q;
	logic       done;
	logic [7:0] byte_sel;
	logic [7:0] crc_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       end_q;
	logic       advance;

	assign advance = head_valid && (!out_valid_q || frame.ready);
	assign pop     = advance && done;

	always_comb begin
		if (started_q) begin
			cur = step_q;
		end else if (head.first) begin
			cur = ST_DEST;
		end else if (head.has_data) begin
			cur = ST_DATA;
		end else begin
			cur = ST_CRC;
		end
		nxt  = ST_CRC;
		done = 1'b0;
		case (cur)
			ST_DEST: begin
				byte_sel = head.dest;
				nxt      = ST_LEN;
			end
			ST_LEN: begin
				byte_sel = head.len_byte;
				nxt      = ST_TYPE;
			end
			ST_TYPE: begin
				byte_sel = head.ftype;
				nxt      = head.has_data ? ST_DATA : ST_CRC;
			end
			ST_DATA: begin
				byte_sel = head.data;
				nxt      = ST_CRC;
				done     = !head.last;
			end
			ST_CRC: begin
				byte_sel = crc_q;
				done     = 1'b1;
			end
			default: begin
				byte_sel = crc_q;
				done     = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_DEST;
			started_q   <= 1'b0;
			crc_q       <= 8'd0;
			out_valid_q <= 1'b0;
			out_byte_q  <= 8'd0;
			last_q      <= 1'b0;
			end_q       <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= byte_sel;
				last_q      <= done;
				end_q       <= (cur == ST_CRC);
				started_q   <= !done;
				step_q      <= nxt;
				case (cur)
					ST_TYPE: crc_q <= cfb_pkg::crc_fold(8'd0, head.ftype, poly);
					ST_DATA: crc_q <= cfb_pkg::crc_fold(crc_q, head.data, poly);
					ST_CRC:  crc_q <= 8'd0;
					default: crc_q <= crc_q;
				endcase
			end else if (frame.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign frame.valid       = out_valid_q;
	assign frame.out_byte    = out_byte_q;
	assign frame.last_of_run = last_q;
	assign frame.frame_end   = end_q;

endmodule

[sv/cfb_checker.sv]
// Port-level checker for the frame builder, bound to the top level.
module cfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       out_end
);

	logic [3:0] outstanding_q;
	logic       in_acc;
	logic       run_done;

	assign in_acc   = in_valid && in_ready;
	assign run_done = out_valid && out_ready && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= 4'd0;
		end else if (in_acc && !run_done) begin
			outstanding_q <= outstanding_q + 4'd1;
		end else if (run_done && !in_acc) begin
			outstanding_q <= outstanding_q - 4'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
		&& $stable(out_end))
		else $error("output byte changed while stalled");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_end |-> out_last)
		else $error("CRC byte not marked as last of run");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> outstanding_q != 4'd0)
		else $error("end of run without a pending input transaction");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q >= 4'd4 |-> !in_ready)
		else $error("input taken beyond queue capacity");

endmodule

bind crsf_frame_builder_crc8 cfb_checker u_cfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (frame.valid),
	.out_ready (frame.ready),
	.out_byte  (frame.out_byte),
	.out_last  (frame.last_of_run),
	.out_end   (frame.frame_end)
);

[dv/tb_top.sv]
// Testbench for the CRSF frame builder: random frames, CRC polynomial sweeps, byte checks.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// One serialized frame byte as seen on the frame channel.
	typedef struct packed {
		logic [7:0] value;
		logic       run_last;
		logic       closes;
	} frame_byte_t;

	// Scoreboard: mirrors the framer state and holds the bytes still owed.
	class frame_scoreboard;
		frame_byte_t owed[$];
		logic [7:0]  poly;
		logic        open;
		logic [7:0]  crc_acc;
		logic [5:0]  remaining;
		int unsigned errors;

		function new();
			poly      = cfb_pkg::CRC_RESET_POLY;
			open      = 1'b0;
			crc_acc   = 8'h00;
			remaining = 6'd0;
			errors    = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function int unsigned pending();
			return owed.size();
		endfunction

		function void set_poly(logic [7:0] p);
			poly = p;
		endfunction

		// MSB-first CRC-8 shift of one byte through the accumulator
		function logic [7:0] crc_shift(logic [7:0] acc, logic [7:0] b);
			logic [7:0] r;
			r = acc ^ b;
			for (int i = 0; i < 8; i++) begin
				r = {r[6:0], 1'b0} ^ (r[7] ? poly : 8'h00);
			end
			return r;
		endfunction

		function void owe(logic [7:0] v, logic run_last, logic closes);
			frame_byte_t fb;
			fb.value    = v;
			fb.run_last = run_last;
			fb.closes   = closes;
			owed.push_back(fb);
		endfunction

		// Accepted input transaction: queue every byte it produces.
		function void note_item(logic [7:0] dest, logic [7:0] ftype, logic [5:0] len,
			logic [7:0] data);
			logic [5:0] eff;
			if (!open) begin
				eff = (len > cfb_pkg::MAX_PAYLOAD) ? cfb_pkg::MAX_PAYLOAD : len;
				owe(dest, 1'b0, 1'b0);
				owe(8'(eff) + cfb_pkg::LEN_OVERHEAD, 1'b0, 1'b0);
				owe(ftype, 1'b0, 1'b0);
				crc_acc = crc_shift(8'h00, ftype);
				if (eff == 6'd0) begin
					owe(crc_acc, 1'b1, 1'b1);
					crc_acc   = 8'h00;
					remaining = 6'd0;
					return;
				end
				remaining = eff;
				open      = 1'b1;
			end
			crc_acc = crc_shift(crc_acc, data);
			if (remaining != 6'd0) remaining--;
			if (remaining == 6'd0) begin
				owe(data, 1'b0, 1'b0);
				owe(crc_acc, 1'b1, 1'b1);
				crc_acc = 8'h00;
				open    = 1'b0;
			end else begin
				owe(data, 1'b1, 1'b0);
			end
		endfunction

		// Accepted output transaction: compare with the oldest owed byte.
		task check_byte(logic [7:0] v, logic run_last, logic closes);
			frame_byte_t fb;
			if (owed.size() == 0) begin
				report($sformatf("unexpected byte %02h", v));
				return;
			end
			fb = owed.pop_front();
			if (v !== fb.value)
				report($sformatf("out_byte %02h, want %02h", v, fb.value));
			if (run_last !== fb.run_last)
				report($sformatf("last_of_run %b, want %b (byte %02h)", run_last,
					fb.run_last, fb.value));
			if (closes !== fb.closes)
				report($sformatf("frame_end %b, want %b (byte %02h)", closes,
					fb.closes, fb.value));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	cfb_in_if  item_ch();
	cfb_out_if frame_ch();
	cfb_cfg_if cfg_ch();

	crsf_frame_builder_crc8 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.frame  (frame_ch),
		.cfg    (cfg_ch)
	);

	frame_scoreboard sb = new();

	// quiet: no idling on either side (final phase)
	bit          quiet;
	bit          paused_once;
	int unsigned items_sent;

	always #4 clk = ~clk;

	// Hard stop well past the slowest legal run (a few hundred frames' worth).
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Output monitor. Values seen here are the ones present at the edge,
	// since the block's registers update later in the same time step.
	always @(posedge clk) begin
		if (arst_n && frame_ch.valid && frame_ch.ready)
			sb.check_byte(frame_ch.out_byte, frame_ch.last_of_run, frame_ch.frame_end);
	end

	// Receiver backpressure: bursts of ready with short stalls between,
	// plus occasional long stretches with no stall at all.
	initial begin
		frame_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				frame_ch.ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 7) == 0) begin
				frame_ch.ready <= 1'b1;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end else begin
				frame_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				frame_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	// One input transaction. Valid stays high on return so that a following
	// transaction can go out back to back; callers lower it when they pause.
	task automatic push_item(input logic [7:0] dest, input logic [7:0] ftype,
		input logic [5:0] len, input logic [7:0] data);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.dest_address <= dest;
		item_ch.frame_type   <= ftype;
		item_ch.pay_len      <= len;
		item_ch.data_byte    <= data;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(dest, ftype, len, data);
		items_sent++;
	endtask

	// Stop sending and wait until every owed byte has come out.
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Polynomial write; only called with the framer idle.
	task automatic write_poly(input logic [7:0] p);
		cfg_ch.valid <= 1'b1;
		cfg_ch.wdata <= p;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_poly(p);
		cfg_ch.valid <= 1'b0;
	endtask

	// Whole frame with random content. The header fields of later items are
	// random too, so the block is seen to ignore them. The first frame long
	// enough gets a mid-frame pause until all owed bytes are out.
	task automatic send_frame(input logic [5:0] len);
		int n;
		n = (len > cfb_pkg::MAX_PAYLOAD) ? int'(cfb_pkg::MAX_PAYLOAD) : int'(len);
		push_item(8'($urandom), 8'($urandom), len, 8'($urandom));
		for (int i = 1; i < n; i++) begin
			if (!paused_once && i == 2 && n >= 4) begin
				drain();
				paused_once = 1'b1;
			end
			push_item(8'($urandom), 8'($urandom), 6'($urandom), 8'($urandom));
		end
	endtask

	// Mostly short frames, some medium, a few long ones up to and past the saturation point.
	function automatic logic [5:0] pick_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45) return 6'($urandom_range(0, 4));
		if (r < 85) return 6'($urandom_range(5, 16));
		if (r < 95) return 6'($urandom_range(17, 40));
		return 6'($urandom_range(41, 63));
	endfunction

	initial begin
		logic [7:0] polys[5];
		int unsigned phase_start;

		quiet       = 1'b0;
		paused_once = 1'b0;
		items_sent  = 0;
		arst_n               <= 1'b0;
		item_ch.valid        <= 1'b0;
		item_ch.dest_address <= 8'h00;
		item_ch.frame_type   <= 8'h00;
		item_ch.pay_len      <= 6'd0;
		item_ch.data_byte    <= 8'h00;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.wdata         <= 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset polynomial.
		// Zero length frames: header plus CRC, data byte ignored; field extremes.
		push_item(8'hFF, 8'h00, 6'd0, 8'hAA);
		push_item(8'h00, 8'hFF, 6'd0, 8'h55);
		// Single payload byte: five bytes from one transaction.
		push_item(8'hC8, 8'h16, 6'd1, 8'hFF);
		push_item(8'h00, 8'h80, 6'd1, 8'h00);
		// Three byte frame; later transactions carry junk header fields.
		push_item(8'hEE, 8'h14, 6'd3, 8'h00);
		push_item(8'hFF, 8'hFF, 6'd63, 8'h80);
		push_item(8'h00, 8'h00, 6'd0, 8'hFF);
		// Length above the maximum saturates in both count and length byte.
		send_frame(6'd63);

		// Random part: one phase per polynomial, extremes included.
		// Final phase restores the reset value and runs with no idling.
		polys[0] = 8'h00;
		polys[1] = 8'hFF;
		polys[2] = 8'($urandom);
		polys[3] = 8'h07;
		polys[4] = cfb_pkg::CRC_RESET_POLY;
		for (int p = 0; p < 5; p++) begin
			drain();
			repeat (4) @(posedge clk);
			write_poly(polys[p]);
			quiet       = (p == 4);
			phase_start = items_sent;
			while (items_sent - phase_start < 20) send_frame(pick_len());
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
